/* hdl/hlt_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP linear whitespace trimmer package
// Character codes, pending whitespace modes and the per-item result bundle.
// ----------------------------------------------------------------------------
package hlt_pkg;

    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;

    localparam int MAX_RESULTS = 3;

    typedef enum logic [2:0] {
        PM_NONE = 3'd0,
        PM_SP   = 3'd1,
        PM_HT   = 3'd2,
        PM_CR   = 3'd3,
        PM_CRLF = 3'd4,
        PM_RUN  = 3'd5
    } pm_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [1:0]                  count;
    } fold_res_t;

endpackage

/* hdl/http_lws_trimmer.sv */
// ----------------------------------------------------------------------------
// HTTP linear whitespace trimmer
// Folds runs of linear whitespace in an HTTP request byte stream into single
// spaces, drops leading whitespace and stops output at the byte limit.
// ----------------------------------------------------------------------------
// An input byte is registered, then folded into the free result buffer.
// Throughput: one input byte per cycle while the output is not stalled and
// each byte yields at most one output byte; a byte yielding more holds the
// input until the single output port has drained the result buffer.
// Reset clears all request state and loads the output limit with 8192.
module http_lws_trimmer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] out_byte, [24:8] emitted_total
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import hlt_pkg::*;

    localparam int LIMIT_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
    localparam int CNT_W   = COUNT_WIDTH + 1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16'd8192);

    logic [LIMIT_W-1:0] limit_reg;

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               in_eor_reg;

    logic [MAX_RESULTS-1:0][7:0] buf_bytes_reg;
    logic [1:0]         buf_cnt_reg, buf_cnt_next;
    logic [1:0]         buf_idx_reg, buf_idx_next;
    logic [CNT_W-1:0]   buf_base_reg;

    fold_res_t          res;
    logic [CNT_W-1:0]   base_count;
    logic [CNT_W-1:0]   total_w;
    logic               drain_done;
    logic               buf_free;
    logic               step;
    logic               accept;

    hlt_fold #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .LIMIT_W     (LIMIT_W)
    ) u_fold (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .in_byte    (in_byte_reg),
        .in_eor     (in_eor_reg),
        .limit      (limit_reg),
        .res        (res),
        .base_count (base_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata[LIMIT_W-1:0];
        end
    end

    assign m_tvalid   = (buf_cnt_reg != 2'd0);
    assign m_tlast    = (buf_idx_reg == (buf_cnt_reg - 2'd1));
    assign drain_done = m_tvalid && m_tready && m_tlast;
    assign buf_free   = !m_tvalid || drain_done;
    assign step       = in_valid_reg && buf_free;
    assign s_tready   = !in_valid_reg || step;
    assign accept     = s_tvalid && s_tready;

    assign total_w = buf_base_reg + CNT_W'(buf_idx_reg) + CNT_W'(1);
    assign m_tdata = {7'd0, 17'(total_w), buf_bytes_reg[buf_idx_reg]};

    always_comb
    begin
        in_valid_next = in_valid_reg;
        buf_cnt_next  = buf_cnt_reg;
        buf_idx_next  = buf_idx_reg;

        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        priority if (step)
        begin
            buf_cnt_next = res.count;
            buf_idx_next = 2'd0;
        end
        else if (drain_done)
        begin
            buf_cnt_next = 2'd0;
            buf_idx_next = 2'd0;
        end
        else if (m_tvalid && m_tready)
        begin
            buf_idx_next = buf_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            buf_cnt_reg  <= 2'd0;
            buf_idx_reg  <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            buf_cnt_reg  <= buf_cnt_next;
            buf_idx_reg  <= buf_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= s_tdata;
            in_eor_reg  <= s_tlast;
        end
        if (step)
        begin
            buf_bytes_reg <= res.bytes;
            buf_base_reg  <= base_count;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (buf_idx_reg < buf_cnt_reg))
        else $error("result index beyond the buffered byte count");

    a_idx_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (buf_idx_reg == ($past(buf_idx_reg) + 2'd1))))
        else $error("result buffer did not advance after a transaction");

    a_idle_output_takes_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !m_tvalid) |-> (step && s_tready))
        else $error("held input byte not processed while the output is empty");

endmodule

/* hdl/hlt_fold.sv */
// ----------------------------------------------------------------------------
// HTTP linear whitespace trimmer folding core
// Holds the per-request state and works out the zero to three output bytes
// of one input byte combinationally.
// ----------------------------------------------------------------------------
module hlt_fold #(
    parameter int COUNT_WIDTH = 16,
    parameter int LIMIT_W     = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              in_byte,
    input  logic                    in_eor,
    input  logic [LIMIT_W-1:0]      limit,
    output hlt_pkg::fold_res_t      res,
    output logic [COUNT_WIDTH:0]    base_count
);
    import hlt_pkg::*;

    localparam int CNT_W = COUNT_WIDTH + 1;

    pm_t              pm_reg, pm_next;
    logic             started_reg, started_next;
    logic             lws_reg, lws_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hit_reg, hit_next;

    logic             is_ws;
    logic             started_w;
    logic             do_flush;
    logic [1:0]       n;
    logic [MAX_RESULTS-1:0][7:0] bytes;

    always_comb
    begin
        bytes        = '0;
        n            = 2'd0;
        pm_next      = pm_reg;
        is_ws        = (in_byte == CH_SP) || (in_byte == CH_HT) ||
                       (in_byte == CH_CR) || (in_byte == CH_LF);
        started_w    = started_reg || !is_ws;
        do_flush     = (in_byte == CH_CR) || !is_ws ||
                       ((in_byte == CH_LF) && (pm_reg != PM_CR));
        started_next = started_reg;

        if (!hit_reg)
        begin
            started_next = started_w;
            if (started_w)
            begin
                if (do_flush)
                begin
                    unique case (pm_reg)
                        PM_RUN:
                        begin
                            if ((cnt_reg != '0) && !lws_reg)
                            begin
                                bytes[n] = CH_SP;
                                n = n + 2'd1;
                            end
                        end
                        PM_SP:
                        begin
                            bytes[n] = CH_SP;
                            n = n + 2'd1;
                        end
                        PM_HT:
                        begin
                            bytes[n] = CH_HT;
                            n = n + 2'd1;
                        end
                        PM_CR:
                        begin
                            bytes[n] = CH_CR;
                            n = n + 2'd1;
                        end
                        PM_CRLF:
                        begin
                            bytes[n] = CH_CR;
                            n = n + 2'd1;
                            bytes[n] = CH_LF;
                            n = n + 2'd1;
                        end
                        default:
                        begin
                        end
                    endcase
                end

                priority if (in_byte == CH_CR)
                begin
                    pm_next = PM_CR;
                end
                else if (in_byte == CH_LF)
                begin
                    if (pm_reg == PM_CR)
                    begin
                        pm_next = PM_CRLF;
                    end
                    else
                    begin
                        bytes[n] = CH_LF;
                        n = n + 2'd1;
                        pm_next = PM_NONE;
                    end
                end
                else if ((in_byte == CH_SP) || (in_byte == CH_HT))
                begin
                    if (pm_reg == PM_CR)
                    begin
                        bytes[n] = CH_CR;
                        n = n + 2'd1;
                        pm_next = (in_byte == CH_SP) ? PM_SP : PM_HT;
                    end
                    else if ((pm_reg == PM_SP) || (pm_reg == PM_HT) ||
                             (pm_reg == PM_CRLF) || (pm_reg == PM_RUN))
                    begin
                        pm_next = PM_RUN;
                    end
                    else
                    begin
                        pm_next = (in_byte == CH_SP) ? PM_SP : PM_HT;
                    end
                end
                else
                begin
                    bytes[n] = in_byte;
                    n = n + 2'd1;
                    pm_next = PM_NONE;
                end
            end
        end

        cnt_next = cnt_reg + CNT_W'(n);
        lws_next = (n != 2'd0) ? (bytes[n - 2'd1] == CH_SP) : lws_reg;
        hit_next = hit_reg || (!hit_reg && started_w && (cnt_next >= CNT_W'(limit)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_reg      <= PM_NONE;
            started_reg <= 1'b0;
            lws_reg     <= 1'b0;
            cnt_reg     <= '0;
            hit_reg     <= 1'b0;
        end
        else if (step)
        begin
            if (in_eor)
            begin
                pm_reg      <= PM_NONE;
                started_reg <= 1'b0;
                lws_reg     <= 1'b0;
                cnt_reg     <= '0;
                hit_reg     <= 1'b0;
            end
            else
            begin
                pm_reg      <= pm_next;
                started_reg <= started_next;
                lws_reg     <= lws_next;
                cnt_reg     <= cnt_next;
                hit_reg     <= hit_next;
            end
        end
    end

    assign res.bytes  = bytes;
    assign res.count  = n;
    assign base_count = cnt_reg;

    a_no_output_after_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (step && hit_reg) |-> (res.count == 2'd0))
        else $error("bytes produced after the output limit was reached");

    a_eor_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_eor) |=> ((cnt_reg == '0) && (pm_reg == PM_NONE) && !hit_reg))
        else $error("request state not cleared after the final byte");

endmodule

/* tb/http_lws_trimmer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP linear whitespace trimmer testbench
// Streams request bytes into the trimmer with random gaps and output stalls,
// folds each accepted byte through a behavioral model of the whitespace
// rules and compares every output transaction against the bytes it predicts.
// A short table of hand-picked bytes runs first, then random requests under
// several output limits, including the smallest and largest.
// ----------------------------------------------------------------------------
module http_lws_trimmer_tb;

    import hlt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS    = 23;

    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic [16:0] total;
    } out_byte_t;

    typedef struct packed {
        logic [7:0]      ch;
        logic            eor;
        logic            typed;
        logic [1:0]      n;
        logic [0:2][7:0] outs;
    } stim_row_t;

    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{CH_SP, 1'b0, 1'b1, 2'd0, '0},
        '{CH_CR, 1'b0, 1'b1, 2'd0, '0},
        '{CH_LF, 1'b0, 1'b1, 2'd0, '0},
        '{CH_HT, 1'b0, 1'b1, 2'd0, '0},
        '{8'h47, 1'b0, 1'b1, 2'd1, '{8'h47, 8'h00, 8'h00}},
        '{CH_SP, 1'b0, 1'b0, 2'd0, '0},
        '{8'h45, 1'b0, 1'b0, 2'd0, '0},
        '{CH_HT, 1'b0, 1'b0, 2'd0, '0},
        '{CH_SP, 1'b0, 1'b0, 2'd0, '0},
        '{8'h54, 1'b0, 1'b0, 2'd0, '0},
        '{CH_CR, 1'b0, 1'b0, 2'd0, '0},
        '{CH_LF, 1'b0, 1'b0, 2'd0, '0},
        '{8'hFF, 1'b0, 1'b1, 2'd3, '{CH_CR, CH_LF, 8'hFF}},
        '{CH_CR, 1'b0, 1'b0, 2'd0, '0},
        '{CH_SP, 1'b0, 1'b0, 2'd0, '0},
        '{CH_LF, 1'b0, 1'b0, 2'd0, '0},
        '{CH_SP, 1'b0, 1'b0, 2'd0, '0},
        '{CH_CR, 1'b0, 1'b0, 2'd0, '0},
        '{CH_LF, 1'b0, 1'b0, 2'd0, '0},
        '{CH_HT, 1'b0, 1'b0, 2'd0, '0},
        '{8'h00, 1'b0, 1'b0, 2'd0, '0},
        '{CH_SP, 1'b1, 1'b0, 2'd0, '0},
        '{8'h41, 1'b1, 1'b1, 2'd1, '{8'h41, 8'h00, 8'h00}}
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    out_byte_t due_bytes [$];
    out_byte_t step_bytes [$];

    pm_t         ws_hold;
    logic        seen_content;
    logic        last_space;
    logic [16:0] sent_count;
    logic        capped;
    logic [15:0] byte_cap;

    bit idle_on    = 1'b1;
    int stall_left = 0;
    int mismatches = 0;
    int cycles     = 0;

    http_lws_trimmer #(
        .COUNT_WIDTH(16)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    task automatic clear_request();
        ws_hold      = PM_NONE;
        seen_content = 1'b0;
        last_space   = 1'b0;
        sent_count   = '0;
        capped       = 1'b0;
    endtask

    task automatic emit_char(input logic [7:0] c);
        out_byte_t r;
        sent_count = sent_count + 17'd1;
        r.ch       = c;
        r.fin      = 1'b0;
        r.total    = sent_count;
        step_bytes.push_back(r);
        last_space = (c == CH_SP);
    endtask

    task automatic flush_hold();
        case (ws_hold)
            PM_RUN:
            begin
                if (sent_count != 0 && !last_space)
                    emit_char(CH_SP);
            end
            PM_SP:   emit_char(CH_SP);
            PM_HT:   emit_char(CH_HT);
            PM_CR:   emit_char(CH_CR);
            PM_CRLF:
            begin
                emit_char(CH_CR);
                emit_char(CH_LF);
            end
            default: ;
        endcase
    endtask

    task automatic fold_byte(input logic [7:0] b, input logic eor);
        step_bytes.delete();
        if (!capped)
        begin
            if (!seen_content && b != CH_SP && b != CH_HT && b != CH_CR && b != CH_LF)
                seen_content = 1'b1;
            if (seen_content)
            begin
                if (b == CH_CR)
                begin
                    flush_hold();
                    ws_hold = PM_CR;
                end
                else if (b == CH_LF)
                begin
                    if (ws_hold == PM_CR)
                        ws_hold = PM_CRLF;
                    else
                    begin
                        flush_hold();
                        emit_char(CH_LF);
                        ws_hold = PM_NONE;
                    end
                end
                else if (b == CH_SP || b == CH_HT)
                begin
                    if (ws_hold == PM_CR)
                    begin
                        emit_char(CH_CR);
                        ws_hold = (b == CH_SP) ? PM_SP : PM_HT;
                    end
                    else if (ws_hold inside {PM_SP, PM_HT, PM_CRLF, PM_RUN})
                        ws_hold = PM_RUN;
                    else
                        ws_hold = (b == CH_SP) ? PM_SP : PM_HT;
                end
                else
                begin
                    flush_hold();
                    emit_char(b);
                    ws_hold = PM_NONE;
                end
                if (sent_count >= {1'b0, byte_cap})
                    capped = 1'b1;
            end
        end
        if (step_bytes.size() > 0)
            step_bytes[step_bytes.size() - 1].fin = 1'b1;
        if (eor)
            clear_request();
    endtask

    task automatic send_item(input logic [7:0] b, input logic eor, input stim_row_t spec);
        logic [16:0] base;
        out_byte_t   r;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eor;
        do
            @(posedge clk);
        while (!s_tready);
        base = sent_count;
        fold_byte(b, eor);
        if (spec.typed)
        begin
            step_bytes.delete();
            for (int j = 0; j < int'(spec.n); j++)
            begin
                r.ch    = spec.outs[j];
                r.fin   = (j == int'(spec.n) - 1);
                r.total = base + 17'(j + 1);
                step_bytes.push_back(r);
            end
        end
        foreach (step_bytes[j])
            due_bytes.push_back(step_bytes[j]);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (due_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cap(input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        byte_cap  = v;
    endtask

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0:       return CH_SP;
            1:       return CH_HT;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    task automatic random_requests(input int items);
        int   sent;
        int   sel;
        int   run;
        logic eor;
        sent = 0;
        while (sent < items)
        begin
            sel = $urandom_range(0, 99);
            eor = ($urandom_range(0, 29) == 0);
            if (sel < 35)
            begin
                send_item(8'($urandom_range(8'h21, 8'h7E)), eor, '0);
                sent++;
            end
            else if (sel < 47)
            begin
                send_item(8'($urandom_range(0, 255)), eor, '0);
                sent++;
            end
            else if (sel < 57)
            begin
                send_item(CH_SP, eor, '0);
                sent++;
            end
            else if (sel < 63)
            begin
                send_item(CH_HT, eor, '0);
                sent++;
            end
            else if (sel < 73)
            begin
                send_item(CH_CR, 1'b0, '0);
                send_item(CH_LF, eor, '0);
                sent += 2;
            end
            else if (sel < 81)
            begin
                send_item(CH_CR, 1'b0, '0);
                send_item(CH_LF, 1'b0, '0);
                send_item($urandom_range(0, 1) ? CH_SP : CH_HT, eor, '0);
                sent += 3;
            end
            else if (sel < 86)
            begin
                send_item(CH_CR, eor, '0);
                sent++;
            end
            else if (sel < 91)
            begin
                send_item(CH_LF, eor, '0);
                sent++;
            end
            else if (sel < 96)
            begin
                run = $urandom_range(2, 4);
                for (int j = 0; j < run; j++)
                    send_item(pick_ws(), 1'b0, '0);
                sent += run;
            end
            else
            begin
                send_item(8'($urandom_range(0, 255)), 1'b1, '0);
                sent++;
            end
        end
        send_item(8'($urandom_range(8'h21, 8'h7E)), 1'b1, '0);
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : out_check
        out_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected transaction: byte %02h last %0b total %0d",
                             m_tdata[7:0], m_tlast, m_tdata[24:8]);
            end
            else
            begin
                want = due_bytes.pop_front();
                if (m_tdata[7:0] !== want.ch || m_tdata[24:8] !== want.total ||
                    m_tlast !== want.fin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected byte %02h last %0b total %0d, got %02h %0b %0d",
                                 want.ch, want.fin, want.total,
                                 m_tdata[7:0], m_tlast, m_tdata[24:8]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("http_lws_trimmer verification failed");
            $finish;
        end
    end

    initial
    begin
        byte_cap = 16'd8192;
        clear_request();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIRECTED[i].ch, DIRECTED[i].eor, DIRECTED[i]);
        settle();

        write_cap(16'd1);
        random_requests(25);
        settle();

        write_cap(16'd65535);
        random_requests(40);
        settle();

        write_cap(16'd3);
        random_requests(40);
        settle();

        write_cap(16'($urandom_range(4, 24)));
        random_requests(40);
        settle();

        write_cap(16'd2);
        random_requests(30);
        settle();

        idle_on = 1'b0;
        write_cap(16'($urandom_range(1, 65535)));
        random_requests(70);
        settle();

        if (mismatches == 0 && due_bytes.size() == 0)
            $display("http_lws_trimmer verification clean");
        else
            $display("http_lws_trimmer verification failed");
        $finish;
    end

endmodule
